// ===== rtl/sync_length_crc8_deframer_macros.svh =====
// assertion macros used by the deframer's drain block
`ifndef SYNC_LENGTH_CRC8_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_CRC8_DEFRAMER_MACROS_SVH

// same-cycle implication, checked on clk and off during reset
`define SLCDF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk and off during reset
`define SLCDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/slcdf_pkg.sv =====
// shared types, constants and crc function of the deframer
package slcdf_pkg;

	localparam int MAX_PAYLOAD = 64;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
	localparam int BYTE_W      = 8;
	localparam int KIND_W      = 2;
	localparam int MAXLEN_W    = 7;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [BYTE_W-1:0]   SYNC_FIRST   = 8'hFF;
	localparam logic [BYTE_W-1:0]   SYNC_SECOND  = 8'h46;
	localparam logic [BYTE_W-1:0]   CRC_POLY     = 8'hD5;
	localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 7'd64;
	localparam logic [PADDR_W-1:0]  ADDR_MAX_LEN = 3'd0;

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_SYNC2 = 3'd1,
		PH_LEN   = 3'd2,
		PH_DATA  = 3'd3,
		PH_CRC   = 3'd4
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_BADCRC  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		DR_IDLE   = 2'd0,
		DR_SINGLE = 2'd1,
		DR_STREAM = 2'd2
	} drain_state_t;

	// end of frame seen by the parser
	typedef struct packed {
		logic             valid;
		logic             crc_ok;
		logic [CNT_W-1:0] count;
	} frame_end_t;

	// payload buffer write request
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
	} buf_wr_t;

	// crc-8 dvb-s2, msb first
	function automatic logic [BYTE_W-1:0] crc8_update(logic [BYTE_W-1:0] crc,
		logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] v;
		v = crc ^ b;
		for (int i = 0; i < BYTE_W; i++) begin
			if (v[BYTE_W-1]) begin
				v = (v << 1) ^ CRC_POLY;
			end else begin
				v = v << 1;
			end
		end
		return v;
	endfunction

endpackage

// ===== rtl/slcdf_ram.sv =====
// payload buffer: one write port, one registered read port
module slcdf_ram (
	input  logic                              clk,
	input  slcdf_pkg::buf_wr_t                wr,
	input  logic                              re,
	input  logic [slcdf_pkg::ADDR_W-1:0]      raddr,
	output logic [slcdf_pkg::BYTE_W-1:0]      rdata
);

	logic [slcdf_pkg::BYTE_W-1:0] mem [slcdf_pkg::MAX_PAYLOAD];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/slcdf_parser.sv =====
// frame parser: sync hunt, length check, payload store and crc
module slcdf_parser (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               take,
	input  logic [slcdf_pkg::BYTE_W-1:0]       rx_byte,
	input  logic [slcdf_pkg::MAXLEN_W-1:0]     max_len,
	output slcdf_pkg::buf_wr_t                 wr,
	output slcdf_pkg::frame_end_t              ev
);

	slcdf_pkg::phase_t                phase_q, phase_d;
	logic [slcdf_pkg::BYTE_W-1:0]     crc_q, crc_d, crc_next;
	logic [slcdf_pkg::CNT_W-1:0]      len_q, len_d;
	logic [slcdf_pkg::CNT_W-1:0]      fill_q, fill_d;
	logic                             len_ok;

	assign crc_next = slcdf_pkg::crc8_update(crc_q, rx_byte);
	assign len_ok   = (rx_byte <= {1'b0, max_len})
		&& (rx_byte <= slcdf_pkg::BYTE_W'(slcdf_pkg::MAX_PAYLOAD));

	always_comb begin
		phase_d   = phase_q;
		crc_d     = crc_q;
		len_d     = len_q;
		fill_d    = fill_q;
		wr.en     = 1'b0;
		wr.addr   = fill_q[slcdf_pkg::ADDR_W-1:0];
		wr.data   = rx_byte;
		ev.valid  = 1'b0;
		ev.crc_ok = (rx_byte == crc_q);
		ev.count  = fill_q;
		if (take) begin
			case (phase_q)
				slcdf_pkg::PH_SYNC2: begin
					if (rx_byte == slcdf_pkg::SYNC_SECOND) begin
						phase_d = slcdf_pkg::PH_LEN;
					end else begin
						phase_d = slcdf_pkg::PH_HUNT;
						crc_d   = '0;
						fill_d  = '0;
					end
				end
				slcdf_pkg::PH_LEN: begin
					if (len_ok) begin
						crc_d   = crc_next;
						len_d   = rx_byte[slcdf_pkg::CNT_W-1:0];
						fill_d  = '0;
						phase_d = (rx_byte == '0) ? slcdf_pkg::PH_CRC : slcdf_pkg::PH_DATA;
					end else begin
						phase_d = slcdf_pkg::PH_HUNT;
						crc_d   = '0;
						fill_d  = '0;
					end
				end
				slcdf_pkg::PH_DATA: begin
					crc_d = crc_next;
					if (fill_q < slcdf_pkg::CNT_W'(slcdf_pkg::MAX_PAYLOAD)) begin
						wr.en  = 1'b1;
						fill_d = fill_q + 1'b1;
					end
					if ((fill_d >= len_q)
						|| (fill_d >= slcdf_pkg::CNT_W'(slcdf_pkg::MAX_PAYLOAD))) begin
						phase_d = slcdf_pkg::PH_CRC;
					end
				end
				slcdf_pkg::PH_CRC: begin
					ev.valid = 1'b1;
					phase_d  = slcdf_pkg::PH_HUNT;
					crc_d    = '0;
					fill_d   = '0;
				end
				default: begin
					phase_d = (rx_byte == slcdf_pkg::SYNC_FIRST)
						? slcdf_pkg::PH_SYNC2 : slcdf_pkg::PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slcdf_pkg::PH_HUNT;
			crc_q   <= '0;
			len_q   <= '0;
			fill_q  <= '0;
		end else begin
			phase_q <= phase_d;
			crc_q   <= crc_d;
			len_q   <= len_d;
			fill_q  <= fill_d;
		end
	end

endmodule

// ===== rtl/slcdf_drain.sv =====
// result sequencer: reads the buffer out and holds the output register
`include "sync_length_crc8_deframer_macros.svh"

module slcdf_drain (
	input  logic                              clk,
	input  logic                              arst_n,
	input  slcdf_pkg::frame_end_t             ev,
	input  logic [slcdf_pkg::BYTE_W-1:0]      rdata,
	output logic                              re,
	output logic [slcdf_pkg::ADDR_W-1:0]      raddr,
	output logic                              busy,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [slcdf_pkg::KIND_W-1:0]      kind,
	output logic [slcdf_pkg::BYTE_W-1:0]      payload_byte,
	output logic                              last
);

	slcdf_pkg::drain_state_t      state_q, state_d;
	slcdf_pkg::kind_t             single_kind_q, single_kind_d;
	logic [slcdf_pkg::CNT_W-1:0]  count_q, count_d;
	logic [slcdf_pkg::CNT_W-1:0]  idx_q, idx_d, idx_inc;
	logic                         out_valid_q;
	slcdf_pkg::kind_t             kind_q, load_kind;
	logic [slcdf_pkg::BYTE_W-1:0] payload_q, load_byte;
	logic                         last_q, load_last;
	logic                         out_free, load;

	assign out_free = !out_valid_q || out_ready;
	assign idx_inc  = idx_q + 1'b1;

	always_comb begin
		state_d       = state_q;
		single_kind_d = single_kind_q;
		count_d       = count_q;
		idx_d         = idx_q;
		re            = 1'b0;
		raddr         = '0;
		load          = 1'b0;
		load_kind     = slcdf_pkg::KIND_PAYLOAD;
		load_byte     = '0;
		load_last     = 1'b0;
		case (state_q)
			slcdf_pkg::DR_IDLE: begin
				if (ev.valid) begin
					if (!ev.crc_ok) begin
						single_kind_d = slcdf_pkg::KIND_BADCRC;
						state_d       = slcdf_pkg::DR_SINGLE;
					end else if (ev.count == '0) begin
						single_kind_d = slcdf_pkg::KIND_EMPTY;
						state_d       = slcdf_pkg::DR_SINGLE;
					end else begin
						re      = 1'b1;
						idx_d   = '0;
						count_d = ev.count;
						state_d = slcdf_pkg::DR_STREAM;
					end
				end
			end
			slcdf_pkg::DR_SINGLE: begin
				if (out_free) begin
					load      = 1'b1;
					load_kind = single_kind_q;
					load_last = 1'b1;
					state_d   = slcdf_pkg::DR_IDLE;
				end
			end
			slcdf_pkg::DR_STREAM: begin
				if (out_free) begin
					load      = 1'b1;
					load_byte = rdata;
					load_last = (idx_inc == count_q);
					if (load_last) begin
						state_d = slcdf_pkg::DR_IDLE;
					end else begin
						// fetch the next byte while this one is loaded
						re    = 1'b1;
						raddr = idx_inc[slcdf_pkg::ADDR_W-1:0];
						idx_d = idx_inc;
					end
				end
			end
			default: begin
				state_d = slcdf_pkg::DR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= slcdf_pkg::DR_IDLE;
			single_kind_q <= slcdf_pkg::KIND_PAYLOAD;
			count_q       <= '0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			single_kind_q <= single_kind_d;
			count_q       <= count_d;
			idx_q         <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q    <= load_kind;
			payload_q <= load_byte;
			last_q    <= load_last;
		end
	end

	assign busy         = (state_q != slcdf_pkg::DR_IDLE);
	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign payload_byte = payload_q;
	assign last         = last_q;

	`SLCDF_ASSERT_NOW(a_event_only_idle, ev.valid, state_q == slcdf_pkg::DR_IDLE, "frame end while draining")
	`SLCDF_ASSERT_NOW(a_idx_in_range, state_q == slcdf_pkg::DR_STREAM, (idx_q < count_q) && (count_q != '0), "read index past frame")
	`SLCDF_ASSERT_NOW(a_marker_shape, out_valid_q && (kind_q != slcdf_pkg::KIND_PAYLOAD), (payload_q == '0) && last_q, "marker result malformed")
	`SLCDF_ASSERT_NEXT(a_single_loads, (state_q == slcdf_pkg::DR_SINGLE) && out_free, out_valid_q && last_q && (state_q == slcdf_pkg::DR_IDLE), "single result not issued")

endmodule

// ===== rtl/sync_length_crc8_deframer.sv =====
// top level of the sync/length/crc-8 deframer
// Bytes are taken one a beat at the input while a frame is parsed: hunt for
// 0xFF then 'F', a length byte checked against max_frame_length (and 64), the
// payload bytes written into a 64 x 8 buffer ram, and a crc-8 dvb-s2 byte over
// length and payload. After the crc byte in_ready drops until the last result
// of that frame has been loaded into the output register: a good frame reads
// its payload out of the ram at one byte per cycle (registered ram read, the
// next address is issued while the current byte loads the output register),
// the first result going through the drain state register and then the
// output register; an empty frame or a crc mismatch gives a single result,
// which takes the same path. A stalled output stretches this beat for beat.
// The buffer needs no clearing pass, since only entries written in the
// current frame are read. max_frame_length is register 0 at apb address 0
// (bits 6:0, reset 64) and is sampled when the length byte arrives.
module sync_length_crc8_deframer (
	input  logic                              clk,
	input  logic                              arst_n,
	// input byte channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [slcdf_pkg::BYTE_W-1:0]      rx_byte,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [slcdf_pkg::KIND_W-1:0]      kind,
	output logic [slcdf_pkg::BYTE_W-1:0]      payload_byte,
	output logic                              last,
	// apb configuration port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [slcdf_pkg::PADDR_W-1:0]     paddr,
	input  logic [slcdf_pkg::PDATA_W-1:0]     pwdata,
	output logic [slcdf_pkg::PDATA_W-1:0]     prdata,
	output logic                              pready
);

	logic [slcdf_pkg::MAXLEN_W-1:0] max_len_q;
	logic                           reg_sel;
	logic                           take;
	logic                           busy;
	slcdf_pkg::buf_wr_t             wr;
	slcdf_pkg::frame_end_t          ev;
	logic                           re;
	logic [slcdf_pkg::ADDR_W-1:0]   raddr;
	logic [slcdf_pkg::BYTE_W-1:0]   rdata;

	// register decode, word aligned
	assign reg_sel = (paddr[slcdf_pkg::PADDR_W-1:2]
		== slcdf_pkg::ADDR_MAX_LEN[slcdf_pkg::PADDR_W-1:2]);
	assign pready  = 1'b1;
	assign prdata  = reg_sel
		? {{(slcdf_pkg::PDATA_W - slcdf_pkg::MAXLEN_W){1'b0}}, max_len_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= slcdf_pkg::MAXLEN_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			max_len_q <= pwdata[slcdf_pkg::MAXLEN_W-1:0];
		end
	end

	// no byte is taken while a frame's results are still going out, which
	// also keeps buffer writes clear of the readout
	assign in_ready = !busy;
	assign take     = in_valid && in_ready;

	slcdf_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.max_len (max_len_q),
		.wr      (wr),
		.ev      (ev)
	);

	slcdf_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	slcdf_drain u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.ev           (ev),
		.rdata        (rdata),
		.re           (re),
		.raddr        (raddr),
		.busy         (busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.payload_byte (payload_byte),
		.last         (last)
	);

endmodule
